### hw/rtl/matrix_inverse_4x4_defines.svh
// assertion macros used by the matrix inverse rtl
`ifndef MATRIX_INVERSE_4X4_DEFINES_SVH
`define MATRIX_INVERSE_4X4_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define MI4_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define MI4_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/mi4_pkg.sv
package mi4_pkg;

  localparam int TOL_BITS = 31;
  localparam int IDX_BITS = 4;

  typedef enum logic [1:0] {
    SRC_ELEM,
    SRC_MINOR,
    SRC_COF
  } src_t;

  typedef enum logic [1:0] {
    TGT_MINOR,
    TGT_COF,
    TGT_DET
  } tgt_t;

  typedef enum logic [1:0] {
    OP_LOAD,
    OP_ADD,
    OP_SUB
  } acc_op_t;

  typedef struct packed {
    logic                mat_we;
    logic [IDX_BITS-1:0] mat_waddr;
    logic [IDX_BITS-1:0] mat_raddr;
    logic [IDX_BITS-1:0] cof_raddr;
    logic [IDX_BITS-1:0] cof_waddr;
    logic                cof_we;
    logic                cof_neg;
    src_t                mcand_src;
    logic                ld_mcand;
    logic                ld_mplier;
    logic                mul_step;
    tgt_t                acc_tgt;
    acc_op_t             acc_op;
    logic                acc_en;
    logic                abs_en;
    logic                div_load;
    logic                div_num;
    logic                div_chk;
    logic                div_step;
    logic                div_fin;
    logic                sing_out;
  } cmd_t;

  typedef struct packed {
    logic mul_last;
    logic div_last;
    logic sing;
  } status_t;

  // address of minor element (n, m) of the 3x3 submatrix for cofactor idx
  function automatic logic [IDX_BITS-1:0] elem_addr(input logic [IDX_BITS-1:0] idx,
                                                    input logic [1:0] n,
                                                    input logic [1:0] m);
    logic [1:0] rr;
    logic [1:0] cc;
    rr = (n >= idx[3:2]) ? n + 2'd1 : n;
    cc = (m >= idx[1:0]) ? m + 2'd1 : m;
    return {rr, cc};
  endfunction

  // adjugate is the transposed cofactor matrix
  function automatic logic [IDX_BITS-1:0] transpose_idx(input logic [IDX_BITS-1:0] idx);
    return {idx[1:0], idx[3:2]};
  endfunction

endpackage

### hw/rtl/matrix_inverse_4x4.sv
// 4x4 matrix inverse, signed fixed point, by cofactors and adjugate.
// input: drive start with one elem_value word per cycle while busy is low;
// sixteen words are taken in row-major order, busy rises after the sixteenth.
// config: cfg_data carries det_zero_tolerance, written when cfg_valid is high
// (cfg_ready is always high); write it only while busy is low.
// output: each result word is on inv_value/inv_index/singular/saturated/last
// for one cycle with strobe high; the receiver must take it then.
// a singular matrix gives one word with singular and last set, otherwise
// sixteen words in row-major order with last on the sixteenth.
// compute: one shared shift-add multiplier does 148 products (cofactors and
// determinant), then one restoring divider computes the inverse words in turn.
// busy is already low in the cycle that carries the last result word, so the
// first element of the next matrix can be taken in that cycle.
// reset (rst, synchronous) returns to loading with the word count cleared and
// the tolerance at zero.
module matrix_inverse_4x4 #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [WORD_BITS-1:0]   elem_value,
  output logic                          strobe,
  output logic signed [WORD_BITS-1:0]   inv_value,
  output logic [mi4_pkg::IDX_BITS-1:0]  inv_index,
  output logic                          singular,
  output logic                          saturated,
  output logic                          last,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [mi4_pkg::TOL_BITS-1:0]  cfg_data
);

  import mi4_pkg::*;

  cmd_t    cmd;
  status_t status;

  mi4_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .status    (status),
    .strobe    (strobe),
    .inv_index (inv_index),
    .singular  (singular),
    .last      (last)
  );

  mi4_datapath #(
    .WORD_BITS (WORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .elem_value (elem_value),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data),
    .inv_value  (inv_value),
    .saturated  (saturated)
  );

endmodule

### hw/rtl/mi4_ram.sv
module mi4_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### hw/rtl/mi4_datapath.sv
module mi4_datapath #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  mi4_pkg::cmd_t                   cmd,
  output mi4_pkg::status_t                status,
  input  logic signed [WORD_BITS-1:0]     elem_value,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [mi4_pkg::TOL_BITS-1:0]    cfg_data,
  output logic signed [WORD_BITS-1:0]     inv_value,
  output logic                            saturated
);

  import mi4_pkg::*;

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int MW  = 2 * W + 1;
  localparam int CW  = 3 * W + 2;
  localparam int AW  = 4 * W + 3;
  localparam int QB  = W + 1;
  localparam int NA  = CW + 2 * F + 1;
  localparam int NW  = ((NA > AW) ? NA : AW) + 1;
  localparam int XA  = AW + 1 + QB;
  localparam int XW  = (NW > XA) ? NW : XA;
  localparam int RW  = AW + 2;
  localparam int TW  = TOL_BITS + 3 * F;
  localparam int PW  = (AW > TW) ? AW : TW;
  localparam int MCW = $clog2(W);
  localparam int DCW = $clog2(QB);

  logic [W-1:0]           mat_rdata;
  logic [CW-1:0]          cof_rdata;
  logic [CW-1:0]          cof_wdata;
  logic signed [W-1:0]    mat_rd_s;
  logic signed [CW-1:0]   cof_rd_s;

  logic [TOL_BITS-1:0]    tol;
  logic signed [AW-1:0]   mcand;
  logic [W-1:0]           mplier;
  logic signed [AW-1:0]   prod;
  logic [MCW-1:0]         mul_cnt;
  logic signed [MW-1:0]   minor;
  logic signed [CW-1:0]   cof_acc;
  logic signed [AW-1:0]   det;
  logic [AW-1:0]          dabs;
  logic                   dneg;
  logic [CW-1:0]          cabs;
  logic                   neg;
  logic [NW-1:0]          num;
  logic                   big;
  logic [RW-1:0]          rem;
  logic [QB-1:0]          low;
  logic [QB-1:0]          quo;
  logic [DCW-1:0]         div_cnt;

  logic signed [AW-1:0]   mcand_sel;
  logic signed [AW-1:0]   addend;
  logic signed [AW-1:0]   prod_next;
  logic [AW:0]            den2;
  logic [RW-1:0]          trial;
  logic                   ge;
  logic [QB-1:0]          lim;
  logic                   over;
  logic [W-1:0]           sat_mag;
  logic [W-1:0]           mag;

  mi4_ram #(.WIDTH(W), .DEPTH(16)) u_mat_ram (
    .clk   (clk),
    .we    (cmd.mat_we),
    .waddr (cmd.mat_waddr),
    .wdata (elem_value),
    .raddr (cmd.mat_raddr),
    .rdata (mat_rdata)
  );

  mi4_ram #(.WIDTH(CW), .DEPTH(16)) u_cof_ram (
    .clk   (clk),
    .we    (cmd.cof_we),
    .waddr (cmd.cof_waddr),
    .wdata (cof_wdata),
    .raddr (cmd.cof_raddr),
    .rdata (cof_rdata)
  );

  assign cfg_ready = 1'b1;
  assign mat_rd_s  = mat_rdata;
  assign cof_rd_s  = cof_rdata;
  assign cof_wdata = cmd.cof_neg ? -cof_acc : cof_acc;

  always_comb begin
    case (cmd.mcand_src)
      SRC_ELEM:  mcand_sel = AW'(mat_rd_s);
      SRC_MINOR: mcand_sel = AW'(minor);
      SRC_COF:   mcand_sel = AW'(cof_rd_s);
      default:   mcand_sel = '0;
    endcase
  end

  // msb-first shift-add, the multiplier sign bit weighs negative
  assign addend    = mplier[W-1] ? mcand : '0;
  assign prod_next = (mul_cnt == '0) ? (prod <<< 1) - addend : (prod <<< 1) + addend;

  assign den2    = {dabs, 1'b0};
  assign trial   = {rem[RW-2:0], low[QB-1]};
  assign ge      = trial >= RW'(den2);
  assign lim     = QB'(1) << (W - 1);
  assign over    = big | (neg ? (quo > lim) : (quo >= lim));
  assign sat_mag = neg ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
  assign mag     = over ? sat_mag : quo[W-1:0];

  assign status.mul_last = mul_cnt == MCW'(W - 1);
  assign status.div_last = div_cnt == DCW'(QB - 1);
  assign status.sing     = PW'(dabs) <= (PW'(tol) << (3 * F));

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= '0;
    end else if (cfg_valid && cfg_ready) begin
      tol <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_mcand) begin
      mcand <= mcand_sel;
    end
    if (cmd.ld_mplier) begin
      mplier  <= mat_rdata;
      prod    <= '0;
      mul_cnt <= '0;
    end else if (cmd.mul_step) begin
      mplier  <= mplier << 1;
      prod    <= prod_next;
      mul_cnt <= mul_cnt + MCW'(1);
    end

    if (cmd.acc_en) begin
      case (cmd.acc_tgt)
        TGT_MINOR: begin
          case (cmd.acc_op)
            OP_LOAD: minor <= prod[MW-1:0];
            OP_ADD:  minor <= minor + prod[MW-1:0];
            OP_SUB:  minor <= minor - prod[MW-1:0];
            default: minor <= minor;
          endcase
        end
        TGT_COF: begin
          case (cmd.acc_op)
            OP_LOAD: cof_acc <= prod[CW-1:0];
            OP_ADD:  cof_acc <= cof_acc + prod[CW-1:0];
            OP_SUB:  cof_acc <= cof_acc - prod[CW-1:0];
            default: cof_acc <= cof_acc;
          endcase
        end
        TGT_DET: begin
          case (cmd.acc_op)
            OP_LOAD: det <= prod;
            OP_ADD:  det <= det + prod;
            OP_SUB:  det <= det - prod;
            default: det <= det;
          endcase
        end
        default: ;
      endcase
    end

    if (cmd.abs_en) begin
      dabs <= det[AW-1] ? -det : det;
      dneg <= det[AW-1];
    end

    if (cmd.div_load) begin
      cabs <= cof_rd_s[CW-1] ? -cof_rd_s : cof_rd_s;
      neg  <= cof_rd_s[CW-1] ^ dneg;
    end
    if (cmd.div_num) begin
      // rounding bias: |c| * 2^(2f+1) + |d| over 2|d|
      num <= (NW'(cabs) << (2 * F + 1)) + NW'(dabs);
    end
    if (cmd.div_chk) begin
      big     <= XW'(num) >= (XW'(den2) << QB);
      rem     <= RW'(num >> QB);
      low     <= num[QB-1:0];
      quo     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      rem     <= ge ? trial - RW'(den2) : trial;
      quo     <= {quo[QB-2:0], ge};
      low     <= low << 1;
      div_cnt <= div_cnt + DCW'(1);
    end

    if (cmd.div_fin) begin
      inv_value <= neg ? -mag : mag;
      saturated <= over;
    end else if (cmd.sing_out) begin
      inv_value <= '0;
      saturated <= 1'b0;
    end
  end

endmodule

### hw/rtl/mi4_ctrl.sv
`include "matrix_inverse_4x4_defines.svh"

module mi4_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  output mi4_pkg::cmd_t                 cmd,
  input  mi4_pkg::status_t              status,
  output logic                          strobe,
  output logic [mi4_pkg::IDX_BITS-1:0]  inv_index,
  output logic                          singular,
  output logic                          last
);

  import mi4_pkg::*;

  typedef enum logic [3:0] {
    S_LOAD,
    S_RD_A,
    S_RD_B,
    S_LD_B,
    S_MUL,
    S_ACC,
    S_COF_WR,
    S_ABS,
    S_TOL,
    S_DIV_RD,
    S_DIV_LD,
    S_DIV_NUM,
    S_DIV_CHK,
    S_DIV_IT,
    S_DIV_FIN
  } state_t;

  state_t              state;
  logic [IDX_BITS-1:0] load_cnt;
  logic [IDX_BITS-1:0] idx;
  logic [1:0]          k;
  logic                p;
  tgt_t                tgt;

  logic                accept;
  logic [1:0]          col_x;
  logic [1:0]          col_y;
  logic [IDX_BITS-1:0] addr_a;
  logic [IDX_BITS-1:0] addr_b;
  logic                div_phase;

  assign busy   = state != S_LOAD;
  assign accept = start && !busy;

  // the two minor columns left over once term column k is removed
  assign col_x = (k == 2'd0) ? 2'd1 : 2'd0;
  assign col_y = (k == 2'd2) ? 2'd1 : 2'd2;

  assign div_phase = (state == S_DIV_RD) || (state == S_DIV_LD);

  always_comb begin
    cmd           = '0;
    cmd.mat_we    = accept;
    cmd.mat_waddr = load_cnt;
    cmd.cof_waddr = idx;
    cmd.cof_neg   = idx[2] ^ idx[0];
    cmd.acc_tgt   = tgt;
    addr_a        = elem_addr(idx, 2'd1, p ? col_y : col_x);
    case (tgt)
      TGT_MINOR: begin
        addr_b        = elem_addr(idx, 2'd2, p ? col_x : col_y);
        cmd.mcand_src = SRC_ELEM;
        cmd.acc_op    = p ? OP_SUB : OP_LOAD;
      end
      TGT_COF: begin
        addr_b        = elem_addr(idx, 2'd0, k);
        cmd.mcand_src = SRC_MINOR;
        cmd.acc_op    = (k == 2'd0) ? OP_LOAD : ((k == 2'd1) ? OP_SUB : OP_ADD);
      end
      TGT_DET: begin
        addr_b        = idx;
        cmd.mcand_src = SRC_COF;
        cmd.acc_op    = (idx == '0) ? OP_LOAD : OP_ADD;
      end
      default: begin
        addr_b        = idx;
        cmd.mcand_src = SRC_ELEM;
        cmd.acc_op    = OP_LOAD;
      end
    endcase
    cmd.mat_raddr = (state == S_RD_A) ? addr_a : addr_b;
    cmd.cof_raddr = div_phase ? transpose_idx(idx) : idx;
    cmd.ld_mcand  = state == S_RD_B;
    cmd.ld_mplier = state == S_LD_B;
    cmd.mul_step  = state == S_MUL;
    cmd.acc_en    = state == S_ACC;
    cmd.cof_we    = state == S_COF_WR;
    cmd.abs_en    = state == S_ABS;
    cmd.sing_out  = (state == S_TOL) && status.sing;
    cmd.div_load  = state == S_DIV_LD;
    cmd.div_num   = state == S_DIV_NUM;
    cmd.div_chk   = state == S_DIV_CHK;
    cmd.div_step  = state == S_DIV_IT;
    cmd.div_fin   = state == S_DIV_FIN;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_LOAD;
      load_cnt  <= '0;
      idx       <= '0;
      k         <= '0;
      p         <= 1'b0;
      tgt       <= TGT_MINOR;
      strobe    <= 1'b0;
      inv_index <= '0;
      singular  <= 1'b0;
      last      <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        S_LOAD: begin
          if (accept) begin
            load_cnt <= load_cnt + IDX_BITS'(1);
            if (load_cnt == '1) begin
              state <= S_RD_A;
              idx   <= '0;
              k     <= '0;
              p     <= 1'b0;
              tgt   <= TGT_MINOR;
            end
          end
        end
        S_RD_A: state <= S_RD_B;
        S_RD_B: state <= S_LD_B;
        S_LD_B: state <= S_MUL;
        S_MUL: begin
          if (status.mul_last) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          state <= S_RD_A;
          case (tgt)
            TGT_MINOR: begin
              if (p) begin
                p   <= 1'b0;
                tgt <= TGT_COF;
              end else begin
                p <= 1'b1;
              end
            end
            TGT_COF: begin
              tgt <= TGT_MINOR;
              if (k == 2'd2) begin
                k     <= '0;
                state <= S_COF_WR;
              end else begin
                k <= k + 2'd1;
              end
            end
            TGT_DET: begin
              if (idx == IDX_BITS'(3)) begin
                idx   <= '0;
                state <= S_ABS;
              end else begin
                idx <= idx + IDX_BITS'(1);
              end
            end
            default: state <= S_LOAD;
          endcase
        end
        S_COF_WR: begin
          state <= S_RD_A;
          idx   <= idx + IDX_BITS'(1);
          if (idx == '1) begin
            tgt <= TGT_DET;
          end
        end
        S_ABS: state <= S_TOL;
        S_TOL: begin
          if (status.sing) begin
            strobe    <= 1'b1;
            inv_index <= '0;
            singular  <= 1'b1;
            last      <= 1'b1;
            state     <= S_LOAD;
          end else begin
            idx   <= '0;
            state <= S_DIV_RD;
          end
        end
        S_DIV_RD:  state <= S_DIV_LD;
        S_DIV_LD:  state <= S_DIV_NUM;
        S_DIV_NUM: state <= S_DIV_CHK;
        S_DIV_CHK: state <= S_DIV_IT;
        S_DIV_IT: begin
          if (status.div_last) begin
            state <= S_DIV_FIN;
          end
        end
        S_DIV_FIN: begin
          strobe    <= 1'b1;
          inv_index <= idx;
          singular  <= 1'b0;
          last      <= idx == '1;
          idx       <= idx + IDX_BITS'(1);
          state     <= (idx == '1) ? S_LOAD : S_DIV_RD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  `MI4_ASSERT_NOW(a_sing_is_last, strobe && singular, last, "singular word not marked last")
  `MI4_ASSERT_NEXT(a_strobe_pulse, strobe, !strobe, "result strobe held two cycles")
  `MI4_ASSERT_NEXT(a_full_goes_busy, accept && (load_cnt == '1), busy,
                   "sixteenth element did not start the computation")
  `MI4_ASSERT_NEXT(a_last_frees, strobe && last, !busy, "still busy after the last word")
  `MI4_ASSERT_NEXT(a_mid_stays_busy, strobe && !last, busy, "idle before the last word")

endmodule
